>>> hw/rtl/biquad_highpass_preprocess_macros.svh
// Assertion helpers for the RTL.
`ifndef BIQUAD_HIGHPASS_PREPROCESS_MACROS_SVH
`define BIQUAD_HIGHPASS_PREPROCESS_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define BHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BHP_ASSERT_IMP(lbl, ante, cons, msg) \
  `BHP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BHP_ASSERT_NXT(lbl, ante, cons, msg) \
  `BHP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/bhp_pkg.sv
`default_nettype none

package bhp_pkg;

  localparam int unsigned CoefFracBits = 28;
  localparam int unsigned FbShift      = CoefFracBits;
  localparam int unsigned FfShift      = CoefFracBits - 16;
  localparam int unsigned CfgIdxW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegA1 = 3'd0,
    RegA2 = 3'd1,
    RegB0 = 3'd2,
    RegB1 = 3'd3,
    RegB2 = 3'd4
  } reg_idx_e;

  typedef logic signed [31:0] coef_t;

  typedef struct packed {
    coef_t a1;
    coef_t a2;
    coef_t b0;
    coef_t b1;
    coef_t b2;
  } coefs_t;

  typedef struct packed {
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [15:0] in_1;
    logic signed [15:0] in_2;
  } hist_t;

  localparam coef_t A1Reset = 32'sd511639552;
  localparam coef_t A2Reset = -32'sd244645887;
  localparam coef_t B0Reset = 32'sd248905728;
  localparam coef_t B1Reset = -32'sd497811968;
  localparam coef_t B2Reset = 32'sd248905945;

endpackage

`default_nettype wire

>>> hw/rtl/bhp_acc.sv
`default_nettype none

// Five parallel products, each term truncated to 32 bits, wrapping sum.
module bhp_acc (
  input  wire logic signed [15:0] sample_i,
  input  wire bhp_pkg::hist_t     hist_i,
  input  wire bhp_pkg::coefs_t    coefs_i,
  output logic signed [31:0]      acc_o
);

  logic signed [31:0] out_1, out_2;
  logic signed [15:0] in_1, in_2;
  logic signed [31:0] a1, a2, b0, b1, b2;

  logic signed [63:0] prod_a1, prod_a2;
  logic signed [47:0] prod_b0, prod_b1, prod_b2;

  logic [31:0] term_a1, term_a2, term_b0, term_b1, term_b2;

  assign out_1 = hist_i.out_1;
  assign out_2 = hist_i.out_2;
  assign in_1  = hist_i.in_1;
  assign in_2  = hist_i.in_2;
  assign a1    = coefs_i.a1;
  assign a2    = coefs_i.a2;
  assign b0    = coefs_i.b0;
  assign b1    = coefs_i.b1;
  assign b2    = coefs_i.b2;

  assign prod_a1 = out_1 * a1;
  assign prod_a2 = out_2 * a2;
  assign prod_b0 = sample_i * b0;
  assign prod_b1 = in_1 * b1;
  assign prod_b2 = in_2 * b2;

  assign term_a1 = prod_a1[bhp_pkg::FbShift +: 32];
  assign term_a2 = prod_a2[bhp_pkg::FbShift +: 32];
  assign term_b0 = prod_b0[bhp_pkg::FfShift +: 32];
  assign term_b1 = prod_b1[bhp_pkg::FfShift +: 32];
  assign term_b2 = prod_b2[bhp_pkg::FfShift +: 32];

  assign acc_o = signed'(term_a1 + term_a2 + term_b0 + term_b1 + term_b2);

endmodule

`default_nettype wire

>>> hw/rtl/biquad_highpass_preprocess.sv
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    sample_in_i, clear_history_i
// out      source     out_valid_o / out_stall_i  sample_out_o
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One sample per cycle sustained while out_stall_i is low; out_valid_o rises
// once the sample has passed the input register, then the result register.
// The recursion closes through the history register: five parallel multipliers and one adder.
// Reset loads the default coefficients and zeroes the history.
// A stalled output holds the result; the input register still takes one more.
`default_nettype none

module biquad_highpass_preprocess (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [15:0]           sample_in_i,
  input  wire logic                         clear_history_i,

  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [15:0]                sample_out_o,

  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bhp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  `include "biquad_highpass_preprocess_macros.svh"

  logic                s1_valid_q;
  logic                s1_clear_q;
  logic signed [15:0]  s1_sample_q;
  logic                out_valid_q;
  logic signed [15:0]  out_sample_q;
  bhp_pkg::hist_t      hist_q, hist_d, hist_use;
  bhp_pkg::coefs_t     coefs_q, coefs_d;
  logic signed [31:0]  acc;
  logic                out_free;
  logic                advance;
  logic                in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;

  assign hist_use = s1_clear_q ? '0 : hist_q;

  bhp_acc u_acc (
    .sample_i (s1_sample_q),
    .hist_i   (hist_use),
    .coefs_i  (coefs_q),
    .acc_o    (acc)
  );

  always_comb begin
    hist_d = hist_q;
    if (advance) begin
      hist_d.in_2  = hist_use.in_1;
      hist_d.in_1  = s1_sample_q;
      hist_d.out_2 = hist_use.out_1;
      hist_d.out_1 = acc;
    end
  end

  always_comb begin
    coefs_d = coefs_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (bhp_pkg::reg_idx_e'(cfg_index_i))
        bhp_pkg::RegA1: coefs_d.a1 = cfg_data_i;
        bhp_pkg::RegA2: coefs_d.a2 = cfg_data_i;
        bhp_pkg::RegB0: coefs_d.b0 = cfg_data_i;
        bhp_pkg::RegB1: coefs_d.b1 = cfg_data_i;
        bhp_pkg::RegB2: coefs_d.b2 = cfg_data_i;
        default:        coefs_d    = coefs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_clear_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      coefs_q     <= '{a1: bhp_pkg::A1Reset, a2: bhp_pkg::A2Reset,
                       b0: bhp_pkg::B0Reset, b1: bhp_pkg::B1Reset,
                       b2: bhp_pkg::B2Reset};
    end else begin
      coefs_q <= coefs_d;
      hist_q  <= hist_d;
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        s1_clear_q <= clear_history_i;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= sample_in_i;
    end
    if (advance) begin
      out_sample_q <= acc[31:16];
    end
  end

  `BHP_ASSERT_IMP(a_stall_needs_item, in_stall_o, s1_valid_q, "stall without buffered item")
  `BHP_ASSERT_NXT(a_result_from_s1, !out_valid_q, !out_valid_q || $past(s1_valid_q),
                  "result appeared without a buffered item")
  `BHP_ASSERT_NXT(a_hist_hold, !advance, $stable(hist_q), "history changed without a transfer")
  `BHP_ASSERT_NXT(a_clear_zeroes, advance && s1_clear_q,
                  hist_q.in_2 == 16'sd0 && hist_q.out_2 == 32'sd0,
                  "clear did not zero old history")

endmodule

`default_nettype wire
